// ===== rtl/warp_thread_coordinate_gen_macros.svh =====
// Assertion macros used by the warp thread coordinate generator top level.
`ifndef WARP_THREAD_COORDINATE_GEN_MACROS_SVH
`define WARP_THREAD_COORDINATE_GEN_MACROS_SVH

// same-cycle implication, off during reset
`define WTCG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define WTCG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also holds across reset
`define WTCG_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/wtcg_pkg.sv =====
// Types, constants and helpers for the warp thread coordinate generator.
`default_nettype none
package wtcg_pkg;

  localparam int MAX_WARP_SIZE = 64;
  localparam int WS_W          = $clog2(MAX_WARP_SIZE + 1);
  localparam int LOCAL_MAX     = 1024;
  localparam int LSZ_W         = 11;
  localparam int COORD_W       = 10;
  localparam int POS_W         = 16;
  localparam int GROUP_W       = 16;
  localparam int WIDX_W        = 10;
  localparam int AREA_W        = 21;
  localparam int CNT_W         = 6;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 11;
  localparam int QDEPTH        = 2;
  localparam int QPTR_W        = 1;
  localparam int QCNT_W        = 2;
  localparam int DIV_CNT_W     = $clog2(POS_W);

  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WARP_SIZE    = 2'd2;

  typedef struct packed {
    logic [GROUP_W-1:0] group_x;
    logic [GROUP_W-1:0] group_y;
    logic [GROUP_W-1:0] group_z;
    logic [POS_W-1:0]   start;
    logic [WS_W-1:0]    ws;
  } req_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

  typedef struct packed {
    logic              start;
    logic [POS_W-1:0]  dividend;
    logic [AREA_W-1:0] divisor;
  } div_cmd_t;

  typedef struct packed {
    logic             done;
    logic [POS_W-1:0] quot;
    logic [POS_W-1:0] rem;
  } div_rsp_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_WAIT_Z,
    B_WAIT_Y,
    B_EMIT
  } back_state_t;

  // zero reads as one, anything above the max saturates
  function automatic logic [LSZ_W-1:0] clamp_local(input logic [LSZ_W-1:0] v);
    logic [LSZ_W-1:0] r;
    if (v == '0) begin
      r = LSZ_W'(1);
    end else if (v > LSZ_W'(LOCAL_MAX)) begin
      r = LSZ_W'(LOCAL_MAX);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/warp_thread_coordinate_gen.sv =====
// Top level of the warp thread coordinate generator.
//
//   port group   dir   handshake            contents
//   in_*         in    in_valid / in_stall  group_x/y/z, warp_index
//   out_*        out   out_valid/out_stall  local_x/y/z, out_group_x/y/z, last_point
//   cfg_*        in    cfg_write            cfg_index, cfg_data
//
// A warp makes two passes through the shared 16-step divider (start over local
// area, then remainder over size x), then one point per cycle while out_stall
// is low. A two-entry queue takes the next request meanwhile.
// Synchronous reset empties the queue and idles both parts; config returns to
// 1/1/32. out_stall holds the current point; in_stall rises only when the queue is full.
`default_nettype none
`include "warp_thread_coordinate_gen_macros.svh"
module warp_thread_coordinate_gen (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_write,
  input  wire logic [wtcg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [wtcg_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [wtcg_pkg::GROUP_W-1:0]      group_x,
  input  wire logic [wtcg_pkg::GROUP_W-1:0]      group_y,
  input  wire logic [wtcg_pkg::GROUP_W-1:0]      group_z,
  input  wire logic [wtcg_pkg::WIDX_W-1:0]       warp_index,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [wtcg_pkg::COORD_W-1:0]           local_x,
  output logic [wtcg_pkg::COORD_W-1:0]           local_y,
  output logic [wtcg_pkg::POS_W-1:0]             local_z,
  output logic [wtcg_pkg::GROUP_W-1:0]           out_group_x,
  output logic [wtcg_pkg::GROUP_W-1:0]           out_group_y,
  output logic [wtcg_pkg::GROUP_W-1:0]           out_group_z,
  output logic                                   last_point
);

  logic [wtcg_pkg::LSZ_W-1:0]  local_size_x;
  logic [wtcg_pkg::LSZ_W-1:0]  local_size_y;
  logic [wtcg_pkg::WS_W-1:0]   warp_size;
  logic [wtcg_pkg::LSZ_W-1:0]  size_x;
  logic [wtcg_pkg::LSZ_W-1:0]  size_y;

  logic                        fifo_push;
  logic                        fifo_pop;
  wtcg_pkg::req_t              push_data;
  wtcg_pkg::req_t              head;
  wtcg_pkg::fifo_stat_t        fifo_stat;
  wtcg_pkg::div_cmd_t          div_cmd;
  wtcg_pkg::div_rsp_t          div_rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_size_x <= wtcg_pkg::LSZ_W'(1);
      local_size_y <= wtcg_pkg::LSZ_W'(1);
      warp_size    <= wtcg_pkg::WS_W'(32);
    end else if (cfg_write) begin
      case (cfg_index)
        wtcg_pkg::REG_LOCAL_SIZE_X: local_size_x <= cfg_data;
        wtcg_pkg::REG_LOCAL_SIZE_Y: local_size_y <= cfg_data;
        wtcg_pkg::REG_WARP_SIZE:    warp_size    <= cfg_data[wtcg_pkg::WS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign size_x = wtcg_pkg::clamp_local(local_size_x);
  assign size_y = wtcg_pkg::clamp_local(local_size_y);

  wtcg_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .group_x    (group_x),
    .group_y    (group_y),
    .group_z    (group_z),
    .warp_index (warp_index),
    .warp_size  (warp_size),
    .fifo_stat  (fifo_stat),
    .push       (fifo_push),
    .push_data  (push_data)
  );

  wtcg_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (fifo_push),
    .push_data (push_data),
    .pop       (fifo_pop),
    .head      (head),
    .stat      (fifo_stat)
  );

  wtcg_div u_div (
    .clk (clk),
    .rst (rst),
    .cmd (div_cmd),
    .rsp (div_rsp)
  );

  wtcg_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .fifo_stat   (fifo_stat),
    .pop         (fifo_pop),
    .size_x      (size_x),
    .size_y      (size_y),
    .div_cmd     (div_cmd),
    .div_rsp     (div_rsp),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .local_x     (local_x),
    .local_y     (local_y),
    .local_z     (local_z),
    .out_group_x (out_group_x),
    .out_group_y (out_group_y),
    .out_group_z (out_group_z),
    .last_point  (last_point)
  );

  `WTCG_ASSERT_IMP(a_pop_not_empty, fifo_pop, !fifo_stat.empty, "pop from empty queue")
  `WTCG_ASSERT_IMP(a_point_has_req, out_valid, !fifo_stat.empty, "point without a request")
  `WTCG_ASSERT_NEXT(a_run_continues, out_valid && !out_stall && !last_point, out_valid && $stable(out_group_x) && $stable(out_group_z), "warp run broke early")
  `WTCG_ASSERT_RST(a_reset_idle, rst, !out_valid && !in_stall, "not idle after reset")

endmodule
`default_nettype wire

// ===== rtl/wtcg_fifo.sv =====
// Short request queue between the front and back parts.
`default_nettype none
module wtcg_fifo (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire wtcg_pkg::req_t      push_data,
  input  wire logic                pop,
  output wtcg_pkg::req_t           head,
  output wtcg_pkg::fifo_stat_t     stat
);

  wtcg_pkg::req_t                    entries [wtcg_pkg::QDEPTH];
  logic [wtcg_pkg::QPTR_W-1:0]       wr_ptr;
  logic [wtcg_pkg::QPTR_W-1:0]       rd_ptr;
  logic [wtcg_pkg::QCNT_W-1:0]       count;

  function automatic logic [wtcg_pkg::QPTR_W-1:0] ptr_inc(
    input logic [wtcg_pkg::QPTR_W-1:0] p
  );
    logic [wtcg_pkg::QPTR_W-1:0] r;
    if (p == wtcg_pkg::QPTR_W'(wtcg_pkg::QDEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + wtcg_pkg::QPTR_W'(1);
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + wtcg_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - wtcg_pkg::QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  assign head       = entries[rd_ptr];
  assign stat.empty = (count == '0);
  assign stat.full  = (count == wtcg_pkg::QCNT_W'(wtcg_pkg::QDEPTH));

endmodule
`default_nettype wire

// ===== rtl/wtcg_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module wtcg_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire wtcg_pkg::div_cmd_t cmd,
  output wtcg_pkg::div_rsp_t      rsp
);

  logic                               busy;
  logic                               done;
  logic [wtcg_pkg::DIV_CNT_W-1:0]     cnt;
  logic [wtcg_pkg::POS_W-1:0]         dq;
  logic [wtcg_pkg::POS_W-1:0]         rem;
  logic [wtcg_pkg::AREA_W-1:0]        dvs;

  logic [wtcg_pkg::POS_W:0]           trial;
  logic [wtcg_pkg::POS_W:0]           diff;
  logic                               ge;
  logic [wtcg_pkg::POS_W-1:0]         rem_next;

  always_comb begin
    trial = {rem, dq[wtcg_pkg::POS_W-1]};
    ge    = {{(wtcg_pkg::AREA_W - wtcg_pkg::POS_W - 1){1'b0}}, trial} >= dvs;
    diff  = trial - dvs[wtcg_pkg::POS_W:0];
    // partial remainder never exceeds the dividend prefix, so it fits POS_W
    rem_next = ge ? diff[wtcg_pkg::POS_W-1:0] : trial[wtcg_pkg::POS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cnt <= wtcg_pkg::DIV_CNT_W'(wtcg_pkg::POS_W - 1);
      dq  <= cmd.dividend;
      rem <= '0;
      dvs <= cmd.divisor;
    end else if (busy) begin
      cnt <= cnt - wtcg_pkg::DIV_CNT_W'(1);
      rem <= rem_next;
      dq  <= {dq[wtcg_pkg::POS_W-2:0], ge};
    end
  end

  assign rsp.done = done;
  assign rsp.quot = dq;
  assign rsp.rem  = rem;

endmodule
`default_nettype wire

// ===== rtl/wtcg_front.sv =====
// Front part: takes warp requests, saturates the warp size, forms the start position.
`default_nettype none
module wtcg_front (
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [wtcg_pkg::GROUP_W-1:0]  group_x,
  input  wire logic [wtcg_pkg::GROUP_W-1:0]  group_y,
  input  wire logic [wtcg_pkg::GROUP_W-1:0]  group_z,
  input  wire logic [wtcg_pkg::WIDX_W-1:0]   warp_index,
  input  wire logic [wtcg_pkg::WS_W-1:0]     warp_size,
  input  wire wtcg_pkg::fifo_stat_t          fifo_stat,
  output logic                               push,
  output wtcg_pkg::req_t                     push_data
);

  logic [wtcg_pkg::WS_W-1:0] ws_sat;

  always_comb begin
    if (warp_size > wtcg_pkg::WS_W'(wtcg_pkg::MAX_WARP_SIZE)) begin
      ws_sat = wtcg_pkg::WS_W'(wtcg_pkg::MAX_WARP_SIZE);
    end else begin
      ws_sat = warp_size;
    end

    push_data.group_x = group_x;
    push_data.group_y = group_y;
    push_data.group_z = group_z;
    // 1023 * 64 still fits the 16-bit position
    push_data.start   = wtcg_pkg::POS_W'(warp_index) * wtcg_pkg::POS_W'(ws_sat);
    push_data.ws      = ws_sat;
  end

  assign in_stall = fifo_stat.full;
  // a zero-size warp produces nothing and is dropped here
  assign push     = in_valid && !fifo_stat.full && (ws_sat != '0);

endmodule
`default_nettype wire

// ===== rtl/wtcg_back.sv =====
// Back part: splits the start position, then steps out one point per cycle unless out_stall holds it.
`default_nettype none
module wtcg_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire wtcg_pkg::req_t                head,
  input  wire wtcg_pkg::fifo_stat_t          fifo_stat,
  output logic                               pop,
  input  wire logic [wtcg_pkg::LSZ_W-1:0]    size_x,
  input  wire logic [wtcg_pkg::LSZ_W-1:0]    size_y,
  output wtcg_pkg::div_cmd_t                 div_cmd,
  input  wire wtcg_pkg::div_rsp_t            div_rsp,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [wtcg_pkg::COORD_W-1:0]       local_x,
  output logic [wtcg_pkg::COORD_W-1:0]       local_y,
  output logic [wtcg_pkg::POS_W-1:0]         local_z,
  output logic [wtcg_pkg::GROUP_W-1:0]       out_group_x,
  output logic [wtcg_pkg::GROUP_W-1:0]       out_group_y,
  output logic [wtcg_pkg::GROUP_W-1:0]       out_group_z,
  output logic                               last_point
);

  wtcg_pkg::back_state_t              state;
  wtcg_pkg::back_state_t              state_next;
  logic [wtcg_pkg::AREA_W-1:0]        area;
  logic [wtcg_pkg::AREA_W-1:0]        area_full;
  logic [wtcg_pkg::COORD_W-1:0]       cur_x;
  logic [wtcg_pkg::COORD_W-1:0]       cur_x_next;
  logic [wtcg_pkg::COORD_W-1:0]       cur_y;
  logic [wtcg_pkg::COORD_W-1:0]       cur_y_next;
  logic [wtcg_pkg::POS_W-1:0]         cur_z;
  logic [wtcg_pkg::POS_W-1:0]         cur_z_next;
  logic [wtcg_pkg::CNT_W-1:0]         point_count;
  logic [wtcg_pkg::CNT_W-1:0]         point_count_next;
  logic                               last;
  logic                               x_wrap;
  logic                               y_wrap;

  // the user must change sizes only while idle (not enforced here) for the registered area to be current
  assign area_full = wtcg_pkg::AREA_W'(size_x) * wtcg_pkg::AREA_W'(size_y);

  always_ff @(posedge clk) begin
    area <= area_full;
  end

  always_comb begin
    last   = (wtcg_pkg::WS_W'(point_count) + wtcg_pkg::WS_W'(1)) == head.ws;
    x_wrap = (wtcg_pkg::LSZ_W'(cur_x) + wtcg_pkg::LSZ_W'(1)) == size_x;
    y_wrap = (wtcg_pkg::LSZ_W'(cur_y) + wtcg_pkg::LSZ_W'(1)) == size_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wtcg_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_x       <= cur_x_next;
    cur_y       <= cur_y_next;
    cur_z       <= cur_z_next;
    point_count <= point_count_next;
  end

  always_comb begin
    state_next       = state;
    cur_x_next       = cur_x;
    cur_y_next       = cur_y;
    cur_z_next       = cur_z;
    point_count_next = point_count;
    pop              = 1'b0;
    div_cmd.start    = 1'b0;
    div_cmd.dividend = head.start;
    div_cmd.divisor  = area;
    case (state)
      wtcg_pkg::B_IDLE: begin
        if (!fifo_stat.empty) begin
          div_cmd.start = 1'b1;
          state_next    = wtcg_pkg::B_WAIT_Z;
        end
      end
      wtcg_pkg::B_WAIT_Z: begin
        div_cmd.dividend = div_rsp.rem;
        div_cmd.divisor  = wtcg_pkg::AREA_W'(size_x);
        if (div_rsp.done) begin
          cur_z_next    = div_rsp.quot;
          div_cmd.start = 1'b1;
          state_next    = wtcg_pkg::B_WAIT_Y;
        end
      end
      wtcg_pkg::B_WAIT_Y: begin
        if (div_rsp.done) begin
          cur_y_next       = div_rsp.quot[wtcg_pkg::COORD_W-1:0];
          cur_x_next       = div_rsp.rem[wtcg_pkg::COORD_W-1:0];
          point_count_next = '0;
          state_next       = wtcg_pkg::B_EMIT;
        end
      end
      wtcg_pkg::B_EMIT: begin
        if (!out_stall) begin
          if (last) begin
            pop        = 1'b1;
            state_next = wtcg_pkg::B_IDLE;
          end else begin
            point_count_next = point_count + wtcg_pkg::CNT_W'(1);
            // x rolls into y, y rolls into z
            if (x_wrap) begin
              cur_x_next = '0;
              if (y_wrap) begin
                cur_y_next = '0;
                cur_z_next = cur_z + wtcg_pkg::POS_W'(1);
              end else begin
                cur_y_next = cur_y + wtcg_pkg::COORD_W'(1);
              end
            end else begin
              cur_x_next = cur_x + wtcg_pkg::COORD_W'(1);
            end
          end
        end
      end
      default: begin
        state_next = wtcg_pkg::B_IDLE;
      end
    endcase
  end

  assign out_valid   = (state == wtcg_pkg::B_EMIT);
  assign local_x     = cur_x;
  assign local_y     = cur_y;
  assign local_z     = cur_z;
  assign out_group_x = head.group_x;
  assign out_group_y = head.group_y;
  assign out_group_z = head.group_z;
  assign last_point  = last;

endmodule
`default_nettype wire
